[src/three_extreme_point_selector_core_defines.svh]
// Assertion macros shared by the selector modules.
// The enclosing module must provide aclk and aresetn.
`ifndef THREE_EXTREME_POINT_SELECTOR_CORE_DEFINES_SVH
`define THREE_EXTREME_POINT_SELECTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define TEPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TEPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/teps_pkg.sv]
package teps_pkg;

    localparam int DEF_IMAGE_WIDTH  = 188;
    localparam int DEF_IMAGE_HEIGHT = 120;
    localparam int DEF_MAX_POINTS   = 256;

    localparam int CNT_W        = 9;
    localparam int V_SAT        = 127;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] point_x;
        logic [6:0] point_y;
        logic       last_point;
    } point_in_t;

    typedef struct packed {
        logic [7:0]  index_far_horizontal;
        logic [7:0]  index_far_vertical;
        logic [7:0]  index_far_product;
        logic [7:0]  score_horizontal;
        logic [6:0]  score_vertical;
        logic [14:0] score_product;
    } result_t;

    typedef struct packed {
        logic [7:0]  h;
        logic [6:0]  v;
        logic [14:0] p;
        logic [7:0]  idx;
        logic        in_range;
        logic        last_point;
    } work_t;

endpackage

[src/teps_front.sv]
module teps_front
    import teps_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
    parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      left_side,
    input  logic      s_valid,
    output logic      s_ready,
    input  point_in_t s_point,
    output logic      q_valid,
    input  logic      q_ready,
    output work_t     q_item
);

`include "three_extreme_point_selector_core_defines.svh"

    localparam logic [7:0]       WIDTH_C  = 8'(IMAGE_WIDTH);
    localparam logic [7:0]       HEIGHT_C = 8'(IMAGE_HEIGHT);
    localparam logic [CNT_W-1:0] MAX_C    = CNT_W'(MAX_POINTS);

    logic             valid_reg, valid_next;
    work_t            item_reg, item_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             in_range;
    logic [7:0]       h;
    logic [7:0]       y_ext;
    logic [7:0]       v_full;
    logic [6:0]       v;

    assign s_ready  = !valid_reg || q_ready;
    assign accept   = s_valid && s_ready;
    assign in_range = cnt_reg < MAX_C;

    always_comb begin
        if (left_side) begin
            h = s_point.point_x;
        end else if (s_point.point_x > WIDTH_C) begin
            h = 8'd0;
        end else begin
            h = WIDTH_C - s_point.point_x;
        end
        y_ext  = {1'b0, s_point.point_y};
        v_full = (y_ext > HEIGHT_C) ? 8'd0 : HEIGHT_C - y_ext;
        v      = (v_full > 8'(V_SAT)) ? 7'(V_SAT) : v_full[6:0];
    end

    always_comb begin
        item_next            = item_reg;
        valid_next           = valid_reg;
        cnt_next             = cnt_reg;
        if (accept) begin
            item_next.h          = h;
            item_next.v          = v;
            item_next.p          = 15'(h) * 15'(v);
            item_next.idx        = cnt_reg[7:0];
            item_next.in_range   = in_range;
            item_next.last_point = s_point.last_point;
            valid_next           = 1'b1;
            if (s_point.last_point) begin
                cnt_next = '0;
            end else if (in_range) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
        item_reg <= item_next;
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    `TEPS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= MAX_C, "Point counter passed its limit.")
    `TEPS_ASSERT_NXT(a_last_resets_cnt, accept && s_point.last_point, cnt_reg == '0,
        "Point counter not cleared after the last point.")

endmodule

[src/teps_queue.sv]
module teps_queue
    import teps_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_item
);

`include "three_extreme_point_selector_core_defines.svh"

    localparam logic [QUEUE_CNT_W-1:0] FULL_C = QUEUE_CNT_W'(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_W-1:0] LAST_C = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    work_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                    push, pop;

    assign in_ready  = count_reg != FULL_C;
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    `TEPS_ASSERT_NXT(a_fills_up, push && !pop && count_reg == FULL_C - 1'b1, !in_ready,
        "Queue did not report full after its last free slot was taken.")

endmodule

[src/teps_back.sv]
module teps_back
    import teps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  work_t   q_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

`include "three_extreme_point_selector_core_defines.svh"

    logic [7:0]  best_h_reg, best_h_next;
    logic [6:0]  best_v_reg, best_v_next;
    logic [14:0] best_p_reg, best_p_next;
    logic [7:0]  idx_h_reg, idx_h_next;
    logic [7:0]  idx_v_reg, idx_v_next;
    logic [7:0]  idx_p_reg, idx_p_next;
    logic [6:0]  v_of_h_reg, v_of_h_next;
    logic [7:0]  h_of_v_reg, h_of_v_next;
    logic        m_valid_reg, m_valid_next;
    result_t     m_result_reg, m_result_next;
    logic        pop;
    logic        h_win, v_win, p_win;
    logic [7:0]  upd_h, upd_idx_h, upd_h_of_v;
    logic [6:0]  upd_v, upd_v_of_h;
    logic [14:0] upd_p;
    logic [7:0]  upd_idx_v, upd_idx_p;

    assign q_ready = !q_item.last_point || !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        h_win = q_item.in_range && (q_item.h > best_h_reg
                || (q_item.h == best_h_reg && q_item.h != '0 && q_item.v > v_of_h_reg));
        v_win = q_item.in_range && (q_item.v > best_v_reg
                || (q_item.v == best_v_reg && q_item.v != '0 && q_item.h > h_of_v_reg));
        p_win = q_item.in_range && (q_item.p > best_p_reg);

        upd_h      = h_win ? q_item.h   : best_h_reg;
        upd_idx_h  = h_win ? q_item.idx : idx_h_reg;
        upd_v_of_h = h_win ? q_item.v   : v_of_h_reg;
        upd_v      = v_win ? q_item.v   : best_v_reg;
        upd_idx_v  = v_win ? q_item.idx : idx_v_reg;
        upd_h_of_v = v_win ? q_item.h   : h_of_v_reg;
        upd_p      = p_win ? q_item.p   : best_p_reg;
        upd_idx_p  = p_win ? q_item.idx : idx_p_reg;
    end

    always_comb begin
        best_h_next   = best_h_reg;
        best_v_next   = best_v_reg;
        best_p_next   = best_p_reg;
        idx_h_next    = idx_h_reg;
        idx_v_next    = idx_v_reg;
        idx_p_next    = idx_p_reg;
        v_of_h_next   = v_of_h_reg;
        h_of_v_next   = h_of_v_reg;
        m_result_next = m_result_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (pop) begin
            if (q_item.last_point) begin
                m_result_next.index_far_horizontal = upd_idx_h;
                m_result_next.index_far_vertical   = upd_idx_v;
                m_result_next.index_far_product    = upd_idx_p;
                m_result_next.score_horizontal     = upd_h;
                m_result_next.score_vertical       = upd_v;
                m_result_next.score_product        = upd_p;
                m_valid_next = 1'b1;
                best_h_next  = '0;
                best_v_next  = '0;
                best_p_next  = '0;
                idx_h_next   = '0;
                idx_v_next   = '0;
                idx_p_next   = '0;
                v_of_h_next  = '0;
                h_of_v_next  = '0;
            end else begin
                best_h_next  = upd_h;
                best_v_next  = upd_v;
                best_p_next  = upd_p;
                idx_h_next   = upd_idx_h;
                idx_v_next   = upd_idx_v;
                idx_p_next   = upd_idx_p;
                v_of_h_next  = upd_v_of_h;
                h_of_v_next  = upd_h_of_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_h_reg  <= '0;
            best_v_reg  <= '0;
            best_p_reg  <= '0;
            idx_h_reg   <= '0;
            idx_v_reg   <= '0;
            idx_p_reg   <= '0;
            v_of_h_reg  <= '0;
            h_of_v_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            best_h_reg  <= best_h_next;
            best_v_reg  <= best_v_next;
            best_p_reg  <= best_p_next;
            idx_h_reg   <= idx_h_next;
            idx_v_reg   <= idx_v_next;
            idx_p_reg   <= idx_p_next;
            v_of_h_reg  <= v_of_h_next;
            h_of_v_reg  <= h_of_v_next;
            m_valid_reg <= m_valid_next;
        end
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    `TEPS_ASSERT_NXT(a_last_clears, pop && q_item.last_point,
        m_valid_reg && best_h_reg == '0 && best_v_reg == '0 && best_p_reg == '0,
        "Maxima not cleared or no result after the last point.")
    `TEPS_ASSERT_IMP(a_stall_holds_last, m_valid_reg && !m_ready && q_item.last_point,
        !q_ready, "Last point taken while the previous result was stalled.")

endmodule

[src/three_extreme_point_selector_core.sv]
// Picks the three extreme points of one lane edge from a stream of boundary points.
// Input: one point per transfer on s_valid/s_ready (s_point); the point that carries
// last_point closes the set. Output: one result per set on m_valid/m_ready (m_result)
// with the indices and scores of the farthest horizontal, farthest vertical and
// largest-product points. cfg_we/cfg_wdata write left_side; write it only while idle.
// Throughput is one point per cycle while no last point waits on a stalled receiver, set
// by the compare-and-update of the running maxima in the back end; the product is formed
// ahead of it in the front stage. A result reaches m_valid from the last point's transfer
// through the front register, the two-entry queue and the output register.
// When the receiver stalls, the back end keeps absorbing ordinary points; only a
// last point waits for the output register, then the queue and front fill and
// s_ready falls. Reset clears all maxima and the point count and sets left_side.
module three_extreme_point_selector_core
    import teps_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
    parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  point_in_t s_point,
    output logic      m_valid,
    input  logic      m_ready,
    output result_t   m_result
);

    logic  left_side_reg;
    logic  fq_valid, fq_ready;
    work_t fq_item;
    logic  qb_valid, qb_ready;
    work_t qb_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_side_reg <= 1'b1;
        end else if (cfg_we) begin
            left_side_reg <= cfg_wdata;
        end
    end

    teps_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .MAX_POINTS   (MAX_POINTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .left_side (left_side_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_point   (s_point),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    teps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    teps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import teps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_POINTS   = 220;

    class extreme_tracker;
        bit      left_side = 1'b1;
        int      count;
        int      best_h;
        int      best_v;
        int      best_p;
        int      idx_h;
        int      idx_v;
        int      idx_p;
        int      v_of_h;
        int      h_of_v;
        result_t pending_results[$];
        int      errors;
        int      points_seen;
        int      results_checked;
        int      overfull_sets;

        function void clear_set();
            count  = 0;
            best_h = 0;
            best_v = 0;
            best_p = 0;
            idx_h  = 0;
            idx_v  = 0;
            idx_p  = 0;
            v_of_h = 0;
            h_of_v = 0;
        endfunction

        function void take_point(point_in_t pt);
            int      h;
            int      v;
            int      p;
            int      idx;
            result_t r;
            points_seen++;
            if (count < DEF_MAX_POINTS) begin
                idx = count & 255;
                if (left_side) begin
                    h = int'(pt.point_x);
                end else begin
                    h = (int'(pt.point_x) > DEF_IMAGE_WIDTH) ? 0
                        : DEF_IMAGE_WIDTH - int'(pt.point_x);
                end
                h = h & 255;
                v = (int'(pt.point_y) > DEF_IMAGE_HEIGHT) ? 0
                    : DEF_IMAGE_HEIGHT - int'(pt.point_y);
                if (v > V_SAT) begin
                    v = V_SAT;
                end
                p = h * v;
                if (h > best_h || (h == best_h && p > best_h * v_of_h)) begin
                    best_h = h;
                    idx_h  = idx;
                    v_of_h = v;
                end
                if (v > best_v || (v == best_v && p > best_v * h_of_v)) begin
                    best_v = v;
                    idx_v  = idx;
                    h_of_v = h;
                end
                if (p > best_p) begin
                    best_p = p;
                    idx_p  = idx;
                end
                count++;
            end
            if (pt.last_point) begin
                if (count >= DEF_MAX_POINTS) begin
                    overfull_sets++;
                end
                r.index_far_horizontal = 8'(idx_h);
                r.index_far_vertical   = 8'(idx_v);
                r.index_far_product    = 8'(idx_p);
                r.score_horizontal     = 8'(best_h);
                r.score_vertical       = 7'(best_v);
                r.score_product        = 15'(best_p);
                pending_results.push_back(r);
                clear_set();
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("Result transfer arrived with no point set pending.");
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got.index_far_horizontal != want.index_far_horizontal)
                report_mismatch($sformatf("index_far_horizontal got %0d, expected %0d",
                    got.index_far_horizontal, want.index_far_horizontal));
            if (got.index_far_vertical != want.index_far_vertical)
                report_mismatch($sformatf("index_far_vertical got %0d, expected %0d",
                    got.index_far_vertical, want.index_far_vertical));
            if (got.index_far_product != want.index_far_product)
                report_mismatch($sformatf("index_far_product got %0d, expected %0d",
                    got.index_far_product, want.index_far_product));
            if (got.score_horizontal != want.score_horizontal)
                report_mismatch($sformatf("score_horizontal got %0d, expected %0d",
                    got.score_horizontal, want.score_horizontal));
            if (got.score_vertical != want.score_vertical)
                report_mismatch($sformatf("score_vertical got %0d, expected %0d",
                    got.score_vertical, want.score_vertical));
            if (got.score_product != want.score_product)
                report_mismatch($sformatf("score_product got %0d, expected %0d",
                    got.score_product, want.score_product));
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    point_in_t s_point;
    logic      m_valid;
    logic      m_ready = 1'b0;
    result_t   m_result;

    extreme_tracker tracker;
    bit        no_idle = 1'b0;
    bit        hold_request = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles = 0;

    three_extreme_point_selector_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_point   (s_point),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The receiver decides m_ready once per cycle; a long hold-off lets the block fill up.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                m_ready = 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (!no_idle && $urandom_range(0, 99) < recv_idle_pct) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_result(m_result);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d cycles without a transfer.", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic point_in_t make_point(logic [7:0] x, logic [6:0] y, logic last);
        point_in_t pt;
        pt.point_x    = x;
        pt.point_y    = y;
        pt.last_point = last;
        return pt;
    endfunction

    function automatic point_in_t random_point(logic last);
        logic [7:0] x;
        logic [6:0] y;
        case ($urandom_range(0, 9))
            6:       x = 8'($urandom_range(188, 255));
            7, 8, 9: begin
                case ($urandom_range(0, 4))
                    0:       x = 8'd0;
                    1:       x = 8'd1;
                    2:       x = 8'd94;
                    3:       x = 8'd187;
                    default: x = 8'd188;
                endcase
            end
            default: x = 8'($urandom_range(0, 187));
        endcase
        case ($urandom_range(0, 9))
            6:       y = 7'($urandom_range(120, 127));
            7, 8, 9: begin
                case ($urandom_range(0, 3))
                    0:       y = 7'd0;
                    1:       y = 7'd60;
                    2:       y = 7'd119;
                    default: y = 7'd120;
                endcase
            end
            default: y = 7'($urandom_range(0, 119));
        endcase
        return make_point(x, y, last);
    endfunction

    task send_point(point_in_t pt);
        if (!no_idle && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_point = pt;
        do @(posedge aclk); while (!s_ready);
        tracker.take_point(pt);
        @(negedge aclk);
    endtask

    task send_set(int size);
        for (int i = 0; i < size; i++) begin
            send_point(random_point(i == size - 1));
        end
    endtask

    task wait_idle();
        s_valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task write_side(bit side);
        cfg_we    = 1'b1;
        cfg_wdata = side;
        tracker.left_side = side;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    initial begin
        int sent;
        int size;
        tracker = new();
        tracker.clear_set();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_valid   = 1'b0;
        s_point   = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Left edge from reset: empty maxima, ties on each distance, all-ones fields.
        send_point(make_point(8'd0, 7'd120, 1'b1));
        send_point(make_point(8'd255, 7'd0, 1'b0));
        send_point(make_point(8'd255, 7'd127, 1'b0));
        send_point(make_point(8'd100, 7'd0, 1'b0));
        send_point(make_point(8'd0, 7'd0, 1'b1));
        send_point(make_point(8'd50, 7'd100, 1'b0));
        send_point(make_point(8'd50, 7'd60, 1'b0));
        send_point(make_point(8'd20, 7'd60, 1'b0));
        send_point(make_point(8'd60, 7'd70, 1'b0));
        send_point(make_point(8'd1, 7'd119, 1'b1));
        send_point(make_point(8'haa, 7'h55, 1'b0));
        send_point(make_point(8'h55, 7'h2a, 1'b1));
        wait_idle();

        // Right edge: columns at and past the image width give zero distance.
        write_side(1'b0);
        send_point(make_point(8'd188, 7'd0, 1'b0));
        send_point(make_point(8'd255, 7'd0, 1'b0));
        send_point(make_point(8'd0, 7'd127, 1'b0));
        send_point(make_point(8'd187, 7'd119, 1'b1));
        send_point(make_point(8'd0, 7'd0, 1'b1));

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            write_side(phase % 2 == 0);
            no_idle = (phase == 5);
            recv_idle_pct = no_idle ? 0 : $urandom_range(5, 40);
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_POINTS) begin
                if ((phase == 1 || phase == 3) && sent == 0) begin
                    size = $urandom_range(257, 270);
                end else if (phase == 2) begin
                    size = $urandom_range(1, 3);
                end else begin
                    size = $urandom_range(1, 24);
                end
                case ($urandom_range(0, 2))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 15;
                    default: send_idle_pct = 40;
                endcase
                if (phase == 2) begin
                    send_idle_pct = 0;
                end
                send_set(size);
                sent += size;
            end
        end
        wait_idle();

        $display("Sent %0d boundary points on both edge sides; %0d sets ran past the point cap.",
            tracker.points_seen, tracker.overfull_sets);
        $display("Checked %0d result transfers, %0d mismatches found.",
            tracker.results_checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/teps_pkg.sv
src/teps_front.sv
src/teps_queue.sv
src/teps_back.sv
src/three_extreme_point_selector_core.sv
sim/testbench.sv
